>>> design/wmv_pkg.sv
`timescale 1ns / 1ps

package wmv_pkg;

  // Queue between the accumulator and the result engine, in completed runs.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_NUM_W = 96;
  localparam int DIV_DEN_W = 64;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [15:0] DOF_RESET = 16'd256;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_MEAN = 2'd1;
  localparam logic [1:0] CNT_BOTH = 2'd2;

  // Sums of one finished run.
  typedef struct packed {
    logic [31:0] w;
    logic [47:0] s1;
    logic [63:0] s2;
  } sums_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> design/wmv_if.sv
`timescale 1ns / 1ps

interface wmv_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_value;
  logic        [15:0] sample_weight;
  logic               last_sample;

  modport source (output valid, output sample_value, output sample_weight,
                  output last_sample, input ready);
  modport sink (input valid, input sample_value, input sample_weight,
                input last_sample, output ready);
endinterface

interface wmv_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] mean;
  logic signed [39:0] variance;
  logic        [1:0]  valid_count;

  modport source (output valid, output mean, output variance, output valid_count,
                  input ready);
  modport sink (input valid, input mean, input variance, input valid_count,
                output ready);
endinterface

>>> design/wmv_fifo.sv
`timescale 1ns / 1ps

module wmv_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wmv_pkg::sums_t  push_data,
  input  logic            pop,
  output wmv_pkg::sums_t  pop_data,
  output wmv_pkg::qstat_t stat
);

  wmv_pkg::sums_t                   mem_r [wmv_pkg::QUEUE_DEPTH];
  logic [wmv_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [wmv_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [wmv_pkg::QCNT_W-1:0]       count_r;
  logic                             do_pop;

  localparam logic [wmv_pkg::QPTR_W-1:0] PTR_LAST = wmv_pkg::QPTR_W'(wmv_pkg::QUEUE_DEPTH - 1);

  assign do_pop = pop && (count_r != '0);

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != wmv_pkg::QCNT_W'(wmv_pkg::QUEUE_DEPTH))
    else $error("run queue overflow");
`endif

endmodule

>>> design/wmv_front.sv
`timescale 1ns / 1ps

module wmv_front (
  input  logic            clk,
  input  logic            rst_n,
  wmv_sample_if.sink      in_if,
  input  wmv_pkg::qstat_t qstat,
  output logic            push,
  output wmv_pkg::sums_t  push_data
);

  localparam int FLT_W = wmv_pkg::QCNT_W + 1;

  logic               accept;
  logic [FLT_W-1:0]   in_flight;

  // stage 1: value*weight and value*value
  logic               s1_valid_r;
  logic               s1_last_r;
  logic [15:0]        s1_w_r;
  logic [31:0]        s1_pvw_r;
  logic [30:0]        s1_vv_r;
  logic signed [32:0] pvw_full;
  logic signed [31:0] vv_full;

  // stage 2: value*value*weight
  logic               s2_valid_r;
  logic               s2_last_r;
  logic [15:0]        s2_w_r;
  logic [31:0]        s2_pvw_r;
  logic [45:0]        s2_sq_r;
  logic [46:0]        sq_full;

  // running sums
  logic [31:0]        wsum_r;
  logic [47:0]        vsum_r;
  logic [63:0]        ssum_r;
  logic [31:0]        wsum_nxt;
  logic [47:0]        vsum_nxt;
  logic [63:0]        ssum_nxt;
  logic [32:0]        wsum_ext;
  logic [48:0]        vsum_ext;
  logic [64:0]        ssum_ext;

  // Reserve a queue slot for every run end still in the pipeline.
  assign in_flight = FLT_W'(qstat.count) + FLT_W'(s1_valid_r && s1_last_r)
                   + FLT_W'(s2_valid_r && s2_last_r);
  assign in_if.ready = (in_flight < FLT_W'(wmv_pkg::QUEUE_DEPTH));
  assign accept      = in_if.valid && in_if.ready;

  assign pvw_full = 33'(in_if.sample_value) * 33'($signed({1'b0, in_if.sample_weight}));
  assign vv_full  = 32'(in_if.sample_value) * 32'(in_if.sample_value);
  assign sq_full  = 47'(s1_vv_r) * 47'(s1_w_r);

  always_comb begin
    wsum_ext = {1'b0, wsum_r} + {17'b0, s2_w_r};
    wsum_nxt = wsum_ext[32] ? '1 : wsum_ext[31:0];

    vsum_ext = {vsum_r[47], vsum_r} + {{17{s2_pvw_r[31]}}, s2_pvw_r};
    if (vsum_ext[48] != vsum_ext[47]) begin
      vsum_nxt = vsum_ext[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      vsum_nxt = vsum_ext[47:0];
    end

    ssum_ext = {1'b0, ssum_r} + {19'b0, s2_sq_r};
    ssum_nxt = ssum_ext[64] ? '1 : ssum_ext[63:0];
  end

  assign push         = s2_valid_r && s2_last_r;
  assign push_data.w  = wsum_nxt;
  assign push_data.s1 = vsum_nxt;
  assign push_data.s2 = ssum_nxt;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r <= in_if.last_sample;
      s1_w_r    <= in_if.sample_weight;
      s1_pvw_r  <= pvw_full[31:0];
      s1_vv_r   <= vv_full[30:0];
    end
    s2_last_r <= s1_last_r;
    s2_w_r    <= s1_w_r;
    s2_pvw_r  <= s1_pvw_r;
    s2_sq_r   <= sq_full[45:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      wsum_r     <= '0;
      vsum_r     <= '0;
      ssum_r     <= '0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      if (s2_valid_r) begin
        if (s2_last_r) begin
          // run ends: sums go to the queue, start over
          wsum_r <= '0;
          vsum_r <= '0;
          ssum_r <= '0;
        end else begin
          wsum_r <= wsum_nxt;
          vsum_r <= vsum_nxt;
          ssum_r <= ssum_nxt;
        end
      end
    end
  end

endmodule

>>> design/wmv_div.sv
`timescale 1ns / 1ps

module wmv_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wmv_pkg::div_req_t req,
  output wmv_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [wmv_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [wmv_pkg::DIV_DEN_W-1:0]   rem_r;
  logic [wmv_pkg::DIV_DEN_W-1:0]   den_r;
  logic [wmv_pkg::DIV_NUM_W-1:0]   nq_r;
  logic [wmv_pkg::DIV_DEN_W:0]     shifted;
  logic [wmv_pkg::DIV_DEN_W+1:0]   diff;
  logic                            ge;

  // Dividend bits shift out of the top of nq_r while quotient bits shift in.
  assign shifted = {rem_r, nq_r[wmv_pkg::DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b0, den_r};
  assign ge      = !diff[wmv_pkg::DIV_DEN_W+1];

  assign rsp.done = done_r;
  assign rsp.quo  = nq_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      den_r <= req.den;
      nq_r  <= req.num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[wmv_pkg::DIV_DEN_W-1:0] : shifted[wmv_pkg::DIV_DEN_W-1:0];
      nq_r  <= {nq_r[wmv_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == wmv_pkg::DIV_CNT_W'(wmv_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

endmodule

>>> design/wmv_back.sv
`timescale 1ns / 1ps

module wmv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       dof,
  input  wmv_pkg::qstat_t   qstat,
  input  wmv_pkg::sums_t    q_data,
  output logic              q_pop,
  output wmv_pkg::div_req_t div_req,
  input  wmv_pkg::div_rsp_t div_rsp,
  wmv_result_if.source      out_if
);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MDIV, S_MUL, S_ACC, S_NUMER, S_VDIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_DEN, MS_ALO, MS_AHI, MS_BLL, MS_BLH, MS_BHH
  } mul_step_t;

  state_t      state_r;
  mul_step_t   step_r;

  logic [31:0] w_r;
  logic [63:0] sq_r;
  logic [47:0] mag_r;
  logic        mneg_r;
  logic        dneg_r;
  logic        nneg_r;
  logic [31:0] dmag_r;
  logic [63:0] den_r;
  logic [95:0] a_r;
  logic [95:0] b_r;
  logic [63:0] prod_r;
  logic [23:0] mean_r;
  logic [39:0] var_r;
  logic [1:0]  cnt_r;

  logic        out_valid_r;
  logic [23:0] out_mean_r;
  logic [39:0] out_var_r;
  logic [1:0]  out_cnt_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] dof_ext;
  logic [47:0] s1_mag;
  logic [23:0] mean_lim;
  logic [23:0] mean_sat;
  logic [39:0] var_lim;
  logic [39:0] var_sat;
  logic        var_neg;

  assign dof_ext = {16'b0, dof};
  assign q_pop   = (state_r == S_IDLE) && qstat.valid;
  assign s1_mag  = q_data.s1[47] ? (~q_data.s1 + 48'd1) : q_data.s1;

  assign out_if.valid       = out_valid_r;
  assign out_if.mean        = out_mean_r;
  assign out_if.variance    = out_var_r;
  assign out_if.valid_count = out_cnt_r;

  // Saturate quotient magnitudes, then apply the sign.
  always_comb begin
    mean_lim = 24'h7FFFFF + 24'(mneg_r);
    if ((|div_rsp.quo[95:24]) || (div_rsp.quo[23:0] > mean_lim)) begin
      mean_sat = mean_lim;
    end else begin
      mean_sat = div_rsp.quo[23:0];
    end

    var_neg = nneg_r ^ dneg_r;
    var_lim = 40'h7FFFFFFFFF + 40'(var_neg);
    if ((|div_rsp.quo[95:40]) || (div_rsp.quo[39:0] > var_lim)) begin
      var_sat = var_lim;
    end else begin
      var_sat = div_rsp.quo[39:0];
    end
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      S_PREP: begin
        div_req.start = (w_r != '0);
        div_req.num   = {40'b0, mag_r, 8'b0};
        div_req.den   = {32'b0, w_r};
      end
      S_NUMER: begin
        div_req.start = 1'b1;
        div_req.num   = (a_r < b_r) ? (b_r - a_r) : (a_r - b_r);
        div_req.den   = den_r;
      end
      default: ;
    endcase
  end

  // b = mag^2 is built from 24-bit halves of the magnitude.
  always_comb begin
    case (step_r)
      MS_DEN: begin
        mul_a = w_r;
        mul_b = dmag_r;
      end
      MS_ALO: begin
        mul_a = sq_r[31:0];
        mul_b = w_r;
      end
      MS_AHI: begin
        mul_a = sq_r[63:32];
        mul_b = w_r;
      end
      MS_BLL: begin
        mul_a = {8'b0, mag_r[23:0]};
        mul_b = {8'b0, mag_r[23:0]};
      end
      MS_BLH: begin
        mul_a = {8'b0, mag_r[23:0]};
        mul_b = {8'b0, mag_r[47:24]};
      end
      MS_BHH: begin
        mul_a = {8'b0, mag_r[47:24]};
        mul_b = {8'b0, mag_r[47:24]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= MS_DEN;
      out_valid_r <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid_r && out_if.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (qstat.valid) begin
            w_r     <= q_data.w;
            sq_r    <= q_data.s2;
            mag_r   <= s1_mag;
            mneg_r  <= q_data.s1[47];
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          dneg_r <= (w_r < dof_ext);
          dmag_r <= (w_r < dof_ext) ? (dof_ext - w_r) : (w_r - dof_ext);
          if (w_r == '0) begin
            mean_r  <= '0;
            var_r   <= '0;
            cnt_r   <= wmv_pkg::CNT_NONE;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            mean_r <= mneg_r ? (~mean_sat + 24'd1) : mean_sat;
            cnt_r  <= wmv_pkg::CNT_MEAN;
            if (w_r == dof_ext) begin
              var_r   <= '0;
              state_r <= S_OUT;
            end else begin
              step_r  <= MS_DEN;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= 64'(mul_a) * 64'(mul_b);
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_MUL;
          case (step_r)
            MS_DEN: begin
              den_r  <= prod_r;
              step_r <= MS_ALO;
            end
            MS_ALO: begin
              a_r    <= {32'b0, prod_r};
              step_r <= MS_AHI;
            end
            MS_AHI: begin
              a_r    <= a_r + {prod_r, 32'b0};
              step_r <= MS_BLL;
            end
            MS_BLL: begin
              b_r    <= {32'b0, prod_r};
              step_r <= MS_BLH;
            end
            MS_BLH: begin
              // cross term counts twice: shift by 24 + 1
              b_r    <= b_r + {7'b0, prod_r, 25'b0};
              step_r <= MS_BHH;
            end
            MS_BHH: begin
              b_r     <= b_r + {prod_r[47:0], 48'b0};
              state_r <= S_NUMER;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_NUMER: begin
          nneg_r  <= (a_r < b_r);
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            var_r   <= var_neg ? (~var_sat + 40'd1) : var_sat;
            cnt_r   <= wmv_pkg::CNT_BOTH;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= mean_r;
            out_var_r   <= var_r;
            out_cnt_r   <= cnt_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_var_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VDIV |-> den_r != '0)
    else $error("variance divide with zero denominator");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_MDIV || state_r == S_VDIV))
    else $error("divider finished outside a divide state");
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && cnt_r == wmv_pkg::CNT_NONE) |-> (mean_r == '0 && var_r == '0))
    else $error("invalid result not zero");
`endif

endmodule

>>> design/weighted_mean_variance_top.sv
`timescale 1ns / 1ps

// Weighted mean and variance accumulator. Each transfer on in_if is one sample
// (signed Q8.8 value, unsigned Q8.8 weight); samples are taken one per cycle
// while in_if.ready is high, summed into saturating weight, weighted value and
// weighted square sums. The sample with last_sample set closes the run: after
// the two product stages its sums enter a four-run queue and the sums clear,
// so the next run streams in without a gap.
// The result engine drains the queue one run at a time; each run goes through
// two 96-step restoring divisions on one shared divider plus six 32x32 multiply
// steps, fewer when the weight sum is zero or equals dof_correction. Input
// stalls only when four finished runs are waiting in the queue or the pipeline.
// mean is Q8.16, variance Q24.16, both saturated and truncated toward zero;
// valid_count is 0 (weight sum zero, all zero), 1 (mean only) or 2.
// cfg_wr_data sets dof_correction (Q8.8, reset 1.0); write it only when idle.
module weighted_mean_variance_top (
  input  logic          clk,
  input  logic          rst_n,
  wmv_sample_if.sink    in_if,
  wmv_result_if.source  out_if,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data
);

  logic [15:0]       cfg_dof_r;
  logic              push;
  wmv_pkg::sums_t    push_data;
  logic              q_pop;
  wmv_pkg::sums_t    q_data;
  wmv_pkg::qstat_t   qstat;
  wmv_pkg::div_req_t div_req;
  wmv_pkg::div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dof_r <= wmv_pkg::DOF_RESET;
    end else if (cfg_wr_en) begin
      cfg_dof_r <= cfg_wr_data;
    end
  end

  wmv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  wmv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .stat      (qstat)
  );

  wmv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wmv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .dof     (cfg_dof_r),
    .qstat   (qstat),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_if  (out_if)
  );

endmodule
